[rtl/sobm_pkg.sv]
// Shared types, codes and defaults for the slot occupancy bitmap manager.
`timescale 1ns / 1ps

package sobm_pkg;

  // Default slot split: user slots first, then admin slots
  localparam int USER_SLOTS_DEF  = 95;
  localparam int ADMIN_SLOTS_DEF = 4;

  // Operation codes
  localparam logic [2:0] OP_MARK      = 3'd0;
  localparam logic [2:0] OP_CLEAR     = 3'd1;
  localparam logic [2:0] OP_CLR_USER  = 3'd2;
  localparam logic [2:0] OP_CLR_ADMIN = 3'd3;
  localparam logic [2:0] OP_CLR_ALL   = 3'd4;
  localparam logic [2:0] OP_SET_MODE  = 3'd5;
  localparam logic [2:0] OP_SEARCH    = 3'd6;

  // Search range codes
  localparam logic [1:0] RNG_ALL   = 2'd0;
  localparam logic [1:0] RNG_USER  = 2'd1;
  localparam logic [1:0] RNG_ADMIN = 2'd2;

  // Mode codes
  localparam logic [1:0] MODE_NORMAL   = 2'd0;
  localparam logic [1:0] MODE_SECURITY = 2'd1;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NONE_USED = 3'd1;
  localparam logic [2:0] ST_NONE_FREE = 3'd2;
  localparam logic [2:0] ST_BAD_SLOT  = 3'd3;
  localparam logic [2:0] ST_BAD_REQ   = 3'd4;

  // Input beat
  typedef struct packed {
    logic [2:0]        operation;
    logic signed [7:0] slot_id;
    logic [1:0]        search_range;
    logic              search_down;
    logic              search_free;
    logic [1:0]        mode_value;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic [2:0] status;
    logic [6:0] found_id;
    logic [6:0] total_count;
    logic [6:0] user_count;
    logic [2:0] admin_count;
    logic       security_mode;
  } out_beat_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_WORK
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic setup;
    logic work;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_more;
  } dp_stat_t;

endpackage

[rtl/slot_occupancy_bitmap_manager.sv]
// Top level of the slot occupancy bitmap manager: controller plus datapath.
`timescale 1ns / 1ps

// A command beat is taken when start is high and busy is low; its single result
// beat appears on result for exactly one cycle with done high, and the receiver
// cannot stall it. Mark, clear, bulk clears, set mode and any search that examines
// no slot pass through the setup and apply states before the result strobe.
// Otherwise a search examines one slot per cycle through the single bitmap read
// port, at most as many slots as the searched range holds, before the strobe.
// busy drops in the strobe cycle, so the next command may be accepted while the
// result is shown.
module slot_occupancy_bitmap_manager
  import sobm_pkg::*;
#(
  parameter int USER_SLOTS  = USER_SLOTS_DEF,
  parameter int ADMIN_SLOTS = ADMIN_SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  in_beat_t  command,
  output logic      done,
  output out_beat_t result
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer
  sobm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Bitmap and result datapath
  sobm_dpath #(
    .USER_SLOTS  (USER_SLOTS),
    .ADMIN_SLOTS (ADMIN_SLOTS)
  ) u_dpath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .command (command),
    .stat    (stat),
    .result  (result)
  );

endmodule

[rtl/sobm_ctrl.sv]
// Sequencing state machine: accept, set up, then apply or scan slot by slot.
`timescale 1ns / 1ps

module sobm_ctrl
  import sobm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy,
  output logic     done
);

  state_t state;
  state_t state_next;
  logic   done_next;

  // State and strobe registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_SETUP;
      end
      S_SETUP: begin
        state_next = S_WORK;
      end
      S_WORK: begin
        if (!stat.scan_more) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    done_next = 1'b0;
    unique case (state)
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
      end
      S_WORK: begin
        cmd.work  = 1'b1;
        done_next = !stat.scan_more;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

[rtl/sobm_dpath.sv]
// Datapath: occupancy bitmap, counters, mode flag, scan pointer and result fields.
`timescale 1ns / 1ps

module sobm_dpath
  import sobm_pkg::*;
#(
  parameter int USER_SLOTS  = USER_SLOTS_DEF,
  parameter int ADMIN_SLOTS = ADMIN_SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  dp_cmd_t   cmd,
  input  in_beat_t  command,
  output dp_stat_t  stat,
  output out_beat_t result
);

  localparam int TOTAL_SLOTS = USER_SLOTS + ADMIN_SLOTS;
  localparam int SNW = $clog2(TOTAL_SLOTS + 1);   // slot number width
  localparam int IW  = $clog2(TOTAL_SLOTS);       // bit index width
  localparam int UCW = $clog2(USER_SLOTS + 1);
  localparam int ACW = $clog2(ADMIN_SLOTS + 1);
  localparam int TCW = $clog2(TOTAL_SLOTS + 1);

  // Architectural state
  logic [TOTAL_SLOTS-1:0] bitmap;
  logic [UCW-1:0]         user_cnt;
  logic [ACW-1:0]         admin_cnt;
  logic                   security_mode;

  // Per-item registers
  in_beat_t   req;
  logic [SNW-1:0] ptr;
  logic [SNW-1:0] end_ptr;
  logic       scan_go;
  logic       slot_ok;
  logic [2:0] pre_status;
  logic [2:0] status_r;
  logic [SNW-1:0] found_r;

  // Setup decode
  logic [SNW-1:0] ptr_setup;
  logic [SNW-1:0] end_setup;
  logic           go_setup;
  logic           slot_ok_setup;
  logic [2:0]     pre_status_setup;

  // Work-phase signals
  logic [IW-1:0] idx;
  logic          cur_bit;
  logic          match;
  logic          admin_slot;

  always_comb begin
    int   id;
    int   lo;
    int   hi;
    int   start_slot;
    logic in_range;
    logic rng_ok;
    logic empty;

    id = int'(req.slot_id);
    unique case (req.search_range)
      RNG_USER: begin
        lo = 1;
        hi = USER_SLOTS;
      end
      RNG_ADMIN: begin
        lo = USER_SLOTS + 1;
        hi = TOTAL_SLOTS;
      end
      default: begin
        lo = 1;
        hi = TOTAL_SLOTS;
      end
    endcase

    rng_ok = (req.search_range == RNG_USER) || (req.search_range == RNG_ADMIN) ||
             ((req.search_range == RNG_ALL) && !req.search_down && !req.search_free);
    in_range = (id >= lo) && (id <= hi);
    // a start on the range edge leaves nothing to look at
    empty  = in_range && (req.search_down ? (id == lo) : (id == hi));

    if (in_range) start_slot = req.search_down ? id - 1 : id + 1;
    else          start_slot = req.search_down ? hi : lo;

    slot_ok_setup = (id >= 1) && (id <= TOTAL_SLOTS);
    go_setup      = (req.operation == OP_SEARCH) && rng_ok && !empty;
    ptr_setup     = (req.operation == OP_SEARCH) ? SNW'(start_slot) : SNW'(id);
    end_setup     = req.search_down ? SNW'(lo) : SNW'(hi);

    case (req.operation) inside
      OP_MARK, OP_CLEAR:
        pre_status_setup = slot_ok_setup ? ST_OK : ST_BAD_SLOT;
      OP_CLR_USER, OP_CLR_ADMIN, OP_CLR_ALL:
        pre_status_setup = ST_OK;
      OP_SET_MODE:
        pre_status_setup = ((req.mode_value == MODE_NORMAL) ||
                            (req.mode_value == MODE_SECURITY)) ? ST_OK : ST_BAD_REQ;
      OP_SEARCH:
        pre_status_setup = !rng_ok ? ST_BAD_REQ :
                           (req.search_free ? ST_NONE_FREE : ST_NONE_USED);
      default:
        pre_status_setup = ST_BAD_REQ;
    endcase
  end

  // Single read port on the bitmap at the pointer
  assign idx        = IW'(ptr - SNW'(1));
  assign cur_bit    = bitmap[idx];
  assign match      = cur_bit != req.search_free;
  assign admin_slot = ptr > SNW'(USER_SLOTS);

  assign stat.scan_more = scan_go && !match && (ptr != end_ptr);

  // Per-item registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= command;
    end
    if (cmd.setup) begin
      ptr        <= ptr_setup;
      end_ptr    <= end_setup;
      scan_go    <= go_setup;
      slot_ok    <= slot_ok_setup;
      pre_status <= pre_status_setup;
    end
    if (cmd.work) begin
      if (scan_go && match) begin
        status_r <= ST_OK;
        found_r  <= ptr;
      end else begin
        status_r <= pre_status;
        found_r  <= '0;
      end
      if (stat.scan_more) begin
        ptr <= req.search_down ? ptr - SNW'(1) : ptr + SNW'(1);
      end
    end
  end

  // Bitmap, counters and mode
  always_ff @(posedge clk) begin
    if (rst) begin
      bitmap        <= '0;
      user_cnt      <= '0;
      admin_cnt     <= '0;
      security_mode <= 1'b0;
    end else if (cmd.work) begin
      case (req.operation)
        OP_MARK: begin
          if (slot_ok) begin
            if (admin_slot) security_mode <= 1'b1;
            if (!cur_bit) begin
              bitmap[idx] <= 1'b1;
              if (admin_slot) admin_cnt <= admin_cnt + ACW'(1);
              else            user_cnt  <= user_cnt + UCW'(1);
            end
          end
        end
        OP_CLEAR: begin
          if (slot_ok && cur_bit) begin
            bitmap[idx] <= 1'b0;
            if (admin_slot) admin_cnt <= admin_cnt - ACW'(1);
            else            user_cnt  <= user_cnt - UCW'(1);
          end
        end
        OP_CLR_USER: begin
          for (int i = 0; i < USER_SLOTS; i++) bitmap[i] <= 1'b0;
          user_cnt <= '0;
        end
        OP_CLR_ADMIN: begin
          for (int i = USER_SLOTS; i < TOTAL_SLOTS; i++) bitmap[i] <= 1'b0;
          admin_cnt     <= '0;
          security_mode <= 1'b0;
        end
        OP_CLR_ALL: begin
          bitmap        <= '0;
          user_cnt      <= '0;
          admin_cnt     <= '0;
          security_mode <= 1'b0;
        end
        OP_SET_MODE: begin
          if ((req.mode_value == MODE_NORMAL) || (req.mode_value == MODE_SECURITY)) begin
            security_mode <= req.mode_value[0];
          end
        end
        default: begin
          security_mode <= security_mode;
        end
      endcase
    end
  end

  // Result beat, read from registers during the strobe cycle
  always_comb begin
    result.status        = status_r;
    result.found_id      = 7'(found_r);
    result.total_count   = 7'(TCW'(user_cnt) + TCW'(admin_cnt));
    result.user_count    = 7'(user_cnt);
    result.admin_count   = 3'(admin_cnt);
    result.security_mode = security_mode;
  end

endmodule
